/* rtl/pal_pkg.sv */
// shared types and constants for the positional array list
// no dependencies; imported by every module of the block but pal_ram

package pal_pkg;

   // field widths of the item and the result
   localparam int CMD_W   = 3;
   localparam int POS_W   = 8;
   localparam int VALUE_W = 32;
   localparam int RDV_W   = 32;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 7;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 48;

   // command codes
   localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_GET     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_REPLACE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
   localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

   localparam logic [POS_W-1:0] POS_APPEND = 8'hFF;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SHIFT,
      S_FIN,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [RDV_W-1:0]   read_value;
      logic [STAT_W-1:0]  status;
      logic [COUNT_W-1:0] entry_count;
      logic               is_empty;
      logic               is_full;
   } rsp_type;

endpackage

/* rtl/pal_ram.sv */
// entry store of the positional array list: one write port, one read port
// read data registered; depends on nothing else

module pal_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/pal_ctrl.sv */
// command sequencer of the positional array list: position checks, fill count
// and the shared index unit that walks the store; uses pal_pkg

module pal_ctrl #(
   parameter int CAPACITY = 64,
   parameter int ENTRY_WIDTH = 32,
   localparam int AW = $clog2(CAPACITY)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [pal_pkg::CMD_W-1:0]    cmd,
   input  logic [pal_pkg::POS_W-1:0]    pos,
   input  logic [pal_pkg::VALUE_W-1:0]  value,
   output logic                         idle,
   output logic                         done_valid,
   input  logic                         done_take,
   output pal_pkg::rsp_type             result,
   output logic                         ram_rd_en,
   output logic [AW-1:0]                ram_rd_addr,
   input  logic [ENTRY_WIDTH-1:0]       ram_rd_data,
   output logic                         ram_wr_en,
   output logic [AW-1:0]                ram_wr_addr,
   output logic [ENTRY_WIDTH-1:0]       ram_wr_data
);

   import pal_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > 7) ? CW : 7;

   state_type state_ff, state_in;

   logic [CW-1:0]          fill_ff, fill_in;
   logic [CMD_W-1:0]       cmd_ff, cmd_in;
   logic [AW-1:0]          pos_ff, pos_in;
   logic [ENTRY_WIDTH-1:0] val_ff, val_in;
   logic [AW-1:0]          rd_idx_ff, rd_idx_in;
   logic [AW-1:0]          end_ff, end_in;
   logic                   rd_more_ff, rd_more_in;
   logic                   first_ff, first_in;
   logic                   wr_pend_ff, wr_pend_in;
   logic [AW-1:0]          wr_addr_ff, wr_addr_in;
   logic                   cap_pend_ff, cap_pend_in;
   logic [ENTRY_WIDTH-1:0] rdv_ff, rdv_in;
   logic [STAT_W-1:0]      status_ff, status_in;

   // position checks
   logic          pos_neg, pos_app, ins_ok, idx_ok, list_full, go_down;
   logic [PW-1:0] pos_mag, fill_w, ins_tgt;
   logic [CW-1:0] fill_m1;
   logic [63:0]   value_w, rdv_w;
   logic [CW+6:0] count_w;

   assign pos_neg   = pos[POS_W-1];
   assign pos_app   = (pos == POS_APPEND);
   assign pos_mag   = PW'(pos[POS_W-2:0]);
   assign fill_w    = PW'(fill_ff);
   assign fill_m1   = fill_ff - CW'(1);
   assign ins_tgt   = pos_app ? fill_w : pos_mag;
   assign ins_ok    = pos_app || (!pos_neg && (pos_mag <= fill_w));
   assign idx_ok    = !pos_neg && (pos_mag < fill_w);
   assign list_full = (fill_ff == CW'(CAPACITY));
   assign value_w   = {32'b0, value};
   assign go_down   = (cmd_ff == CMD_INSERT);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_DONE;
               case (cmd) inside
                  CMD_INSERT: begin
                     if (ins_ok && !list_full) begin
                        state_in = (ins_tgt < fill_w) ? S_SHIFT : S_FIN;
                     end
                  end
                  CMD_REMOVE, CMD_GET: begin
                     if (idx_ok) state_in = S_SHIFT;
                  end
                  CMD_REPLACE: begin
                     if (idx_ok) state_in = S_FIN;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_SHIFT: begin
            if (!rd_more_ff && !wr_pend_ff && !cap_pend_ff) state_in = S_FIN;
         end
         S_FIN: state_in = S_DONE;
         S_DONE: begin
            if (done_take) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      fill_in     = fill_ff;
      cmd_in      = cmd_ff;
      pos_in      = pos_ff;
      val_in      = val_ff;
      rd_idx_in   = rd_idx_ff;
      end_in      = end_ff;
      rd_more_in  = rd_more_ff;
      first_in    = first_ff;
      wr_pend_in  = wr_pend_ff;
      wr_addr_in  = wr_addr_ff;
      cap_pend_in = cap_pend_ff;
      rdv_in      = rdv_ff;
      status_in   = status_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = rd_idx_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = wr_addr_ff;
      ram_wr_data = ram_rd_data;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in      = cmd;
               val_in      = value_w[ENTRY_WIDTH-1:0];
               rdv_in      = '0;
               status_in   = ST_OK;
               first_in    = 1'b1;
               wr_pend_in  = 1'b0;
               cap_pend_in = 1'b0;
               rd_more_in  = 1'b0;
               pos_in      = pos_mag[AW-1:0];
               rd_idx_in   = pos_mag[AW-1:0];
               end_in      = fill_m1[AW-1:0];
               case (cmd)
                  CMD_INSERT: begin
                     pos_in = ins_tgt[AW-1:0];
                     if (!ins_ok) begin
                        status_in = ST_BADPOS;
                     end else if (list_full) begin
                        status_in = ST_FULL;
                     end else begin
                        // walk down from the last entry to the target
                        rd_idx_in  = fill_m1[AW-1:0];
                        end_in     = ins_tgt[AW-1:0];
                        rd_more_in = (ins_tgt < fill_w);
                     end
                  end
                  CMD_REMOVE: begin
                     if (!idx_ok) status_in = ST_BADPOS;
                     else rd_more_in = 1'b1;
                  end
                  CMD_GET: begin
                     end_in = pos_mag[AW-1:0];
                     if (!idx_ok) status_in = ST_BADPOS;
                     else rd_more_in = 1'b1;
                  end
                  CMD_REPLACE: begin
                     if (!idx_ok) status_in = ST_BADPOS;
                  end
                  CMD_CLEAR: fill_in = '0;
                  default: status_in = ST_OK;
               endcase
            end
         end
         S_SHIFT: begin
            ram_rd_en   = rd_more_ff;
            ram_wr_en   = wr_pend_ff;
            // read data lands in the next cycle and goes one slot up or down
            wr_pend_in  = rd_more_ff && (go_down || !first_ff);
            wr_addr_in  = go_down ? rd_idx_ff + AW'(1) : rd_idx_ff - AW'(1);
            cap_pend_in = rd_more_ff && first_ff && !go_down;
            first_in    = 1'b0;
            rd_more_in  = rd_more_ff && (rd_idx_ff != end_ff);
            rd_idx_in   = go_down ? rd_idx_ff - AW'(1) : rd_idx_ff + AW'(1);
            if (cap_pend_ff) rdv_in = ram_rd_data;
         end
         S_FIN: begin
            ram_wr_addr = pos_ff;
            ram_wr_data = val_ff;
            if (cmd_ff == CMD_INSERT || cmd_ff == CMD_REPLACE) ram_wr_en = 1'b1;
            if (cmd_ff == CMD_INSERT) fill_in = fill_ff + CW'(1);
            if (cmd_ff == CMD_REMOVE) fill_in = fill_ff - CW'(1);
         end
         default: begin
            ram_rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         fill_ff     <= '0;
         rd_more_ff  <= 1'b0;
         wr_pend_ff  <= 1'b0;
         cap_pend_ff <= 1'b0;
         first_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         rd_more_ff  <= rd_more_in;
         wr_pend_ff  <= wr_pend_in;
         cap_pend_ff <= cap_pend_in;
         first_ff    <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      pos_ff     <= pos_in;
      val_ff     <= val_in;
      rd_idx_ff  <= rd_idx_in;
      end_ff     <= end_in;
      wr_addr_ff <= wr_addr_in;
      rdv_ff     <= rdv_in;
      status_ff  <= status_in;
   end

   assign rdv_w   = 64'(rdv_ff);
   assign count_w = {7'b0, fill_ff};

   assign idle       = (state_ff == S_IDLE);
   assign done_valid = (state_ff == S_DONE);

   always_comb begin
      result.read_value  = rdv_w[RDV_W-1:0];
      result.status      = status_ff;
      result.entry_count = count_w[COUNT_W-1:0];
      result.is_empty    = (fill_ff == '0);
      result.is_full     = list_full;
   end

endmodule

/* rtl/positional_array_list.sv */
// positional array list: clear, unknown commands, bad positions and full inserts go straight to
// the result, insert at the end and replace first write the entry, a shifting insert or remove
// first walks the store, and get first reads its entry; one item at a time, so the next item is
// taken only once the last result has moved to the output register; the walk moves one entry
// per cycle through the store; synchronous active-high reset empties the list

module positional_array_list #(
   parameter int CAPACITY = 64,
   parameter int ENTRY_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // command [2:0], position [10:3], value [42:11], zero fill above
   input  logic [pal_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // read_value [31:0], status [33:32], entry_count [40:34],
   // is_empty [41], is_full [42], zero fill above
   output logic [pal_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   import pal_pkg::*;

   localparam int AW = $clog2(CAPACITY);

   logic                   idle, start, done_valid, done_take;
   rsp_type                result;
   logic                   ram_rd_en, ram_wr_en;
   logic [AW-1:0]          ram_rd_addr, ram_wr_addr;
   logic [ENTRY_WIDTH-1:0] ram_rd_data, ram_wr_data;

   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   // an item is taken only while the sequencer waits for work
   assign req_tready = idle;
   assign start      = req_tvalid && idle;

   pal_ctrl #(
      .CAPACITY    (CAPACITY),
      .ENTRY_WIDTH (ENTRY_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .cmd         (req_tdata[2:0]),
      .pos         (req_tdata[10:3]),
      .value       (req_tdata[42:11]),
      .idle        (idle),
      .done_valid  (done_valid),
      .done_take   (done_take),
      .result      (result),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data)
   );

   pal_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (ENTRY_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // output register: loads when empty or being drained in the same cycle
   assign done_take = done_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (done_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_data_ff.is_full, rsp_data_ff.is_empty,
                        rsp_data_ff.entry_count, rsp_data_ff.status,
                        rsp_data_ff.read_value};

endmodule

/* rtl/pal_checker.sv */
// port-level checks for the positional array list, bound to the top level
// uses pal_pkg for the status codes

module pal_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [pal_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   import pal_pkg::*;

   // a stalled result holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // one item at a time: no second item straight after an accepted one
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready held after accept");

   // empty flag agrees with the count
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[41] == (rsp_tdata[40:34] == 7'd0)))
      else $error("empty flag disagrees with count");

   // status stays within its codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[33:32] == ST_OK || rsp_tdata[33:32] == ST_BADPOS ||
                      rsp_tdata[33:32] == ST_FULL))
      else $error("status code out of range");

   // nothing is offered right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered out of reset");

endmodule

bind positional_array_list pal_checker u_pal_checker (.*);

/* dv/pal_list_tracker.sv */
// item and result watcher for the positional array list: predicts every result
// from its own copy of the list and compares it field by field
// depends on pal_pkg for the command and status codes and the result struct
`timescale 1ns / 1ps

module pal_list_tracker #(
   parameter int CAPACITY = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   // command [2:0], position [10:3], value [42:11], zero fill above
   input  logic [pal_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // read_value [31:0], status [33:32], entry_count [40:34],
   // is_empty [41], is_full [42], zero fill above
   input  logic [pal_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                             mismatches,
   output int                             awaiting,
   output int                             results_seen,
   output int                             full_seen,
   output int                             refusals
);
   import pal_pkg::*;

   logic [VALUE_W-1:0] list_slots [CAPACITY];
   int                 list_fill;
   rsp_type            expected_results [$];

   // applies one command to the shadow list and returns the result it gives
   function automatic rsp_type list_update(input logic [CMD_W-1:0] cmd,
                                           input logic [POS_W-1:0] pos_raw,
                                           input logic [VALUE_W-1:0] val);
      rsp_type r;
      int      p;
      int      n;
      r = '0;
      p = int'($signed(pos_raw));
      n = list_fill;
      case (cmd)
         CMD_INSERT: begin
            if (p == -1) p = n;
            if (p < 0 || p > n) begin
               r.status = ST_BADPOS;
            end else if (n >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               for (int i = n; i > p; i--) list_slots[i] = list_slots[i-1];
               list_slots[p] = val;
               list_fill++;
            end
         end
         CMD_REMOVE: begin
            if (p < 0 || p >= n) begin
               r.status = ST_BADPOS;
            end else begin
               r.read_value = list_slots[p];
               for (int i = p; i + 1 < n; i++) list_slots[i] = list_slots[i+1];
               list_fill--;
            end
         end
         CMD_GET: begin
            if (p < 0 || p >= n) r.status = ST_BADPOS;
            else r.read_value = list_slots[p];
         end
         CMD_REPLACE: begin
            if (p < 0 || p >= n) r.status = ST_BADPOS;
            else list_slots[p] = val;
         end
         CMD_CLEAR: begin
            list_fill = 0;
         end
         default: begin
         end
      endcase
      r.entry_count = COUNT_W'(list_fill);
      r.is_empty    = (list_fill == 0);
      r.is_full     = (list_fill == CAPACITY);
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type got;
      rsp_type want;
      if (reset) begin
         list_fill = 0;
         expected_results.delete();
      end else begin
         // results first: a result never belongs to an item taken at the same edge
         if (rsp_tvalid && rsp_tready) begin
            got.read_value  = rsp_tdata[31:0];
            got.status      = rsp_tdata[33:32];
            got.entry_count = rsp_tdata[40:34];
            got.is_empty    = rsp_tdata[41];
            got.is_full     = rsp_tdata[42];
            results_seen++;
            if (got.is_full === 1'b1) full_seen++;
            if (expected_results.size() == 0) begin
               $display("%0t: result with none expected, expected nothing, got %0h",
                        $time, rsp_tdata);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               check_field("read_value", want.read_value, got.read_value);
               check_field("status", want.status, got.status);
               check_field("entry_count", want.entry_count, got.entry_count);
               check_field("is_empty", want.is_empty, got.is_empty);
               check_field("is_full", want.is_full, got.is_full);
            end
         end
         if (req_tvalid && req_tready) begin
            want = list_update(req_tdata[2:0], req_tdata[10:3], req_tdata[42:11]);
            if (want.status != ST_OK) refusals++;
            expected_results.push_back(want);
         end
      end
      awaiting = expected_results.size();
   end

endmodule

/* dv/positional_array_list_test.sv */
// top of the positional array list testbench: clock, reset, item stimulus,
// output back-pressure, watchdog and verdict
// depends on pal_pkg, the block and pal_list_tracker
`timescale 1ns / 1ps

module positional_array_list_test;
   import pal_pkg::*;

   localparam int CAPACITY       = 64;
   localparam int RANDOM_ITEMS   = 1900;
   // nothing accepted for this long means the block has hung
   localparam int WATCHDOG_LIMIT = 3000;
   // a full shift walk plus result cycles, with margin
   localparam int DRAIN_CYCLES   = 100;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int send_idle_pct = 20;
   int recv_idle_pct = 54;
   int shadow_fill   = 0;   // entry count as the stimulus sees it, for picking positions
   int items_sent    = 0;
   int stall_cycles  = 0;

   int mismatches;
   int awaiting;
   int results_seen;
   int full_seen;
   int refusals;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   positional_array_list #(
      .CAPACITY    (CAPACITY),
      .ENTRY_WIDTH (32)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   pal_list_tracker #(
      .CAPACITY (CAPACITY)
   ) tracker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .mismatches   (mismatches),
      .awaiting     (awaiting),
      .results_seen (results_seen),
      .full_seen    (full_seen),
      .refusals     (refusals)
   );

   // result side back-pressure, redrawn every cycle
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // watchdog: counts cycles with no item taken on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // drives one item from a falling edge and returns on the falling edge after
   // it has been taken; valid stays high between back-to-back items
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                            input logic [VALUE_W-1:0] val);
      int p;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - 43){1'b0}}, val, pos, cmd};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      // keep the stimulus-side count in step so positions can be aimed
      p = int'($signed(pos));
      case (cmd)
         CMD_INSERT: begin
            if (p == -1) p = shadow_fill;
            if (p >= 0 && p <= shadow_fill && shadow_fill < CAPACITY) shadow_fill++;
         end
         CMD_REMOVE: begin
            if (p >= 0 && p < shadow_fill) shadow_fill--;
         end
         CMD_CLEAR: shadow_fill = 0;
         default: begin
         end
      endcase
      @(negedge clock);
   endtask

   // mostly legal positions for the command, the rest just past the end,
   // negative, far out of range or fully random
   function automatic logic [POS_W-1:0] pick_position(input logic [CMD_W-1:0] cmd);
      int top_legal;
      int r;
      top_legal = (cmd == CMD_INSERT) ? shadow_fill : shadow_fill - 1;
      r = $urandom_range(99);
      if (cmd == CMD_INSERT && r < 12) return POS_APPEND;
      if (r < 85 && top_legal >= 0) return POS_W'($urandom_range(top_legal));
      case ($urandom_range(3))
         0: return POS_W'(top_legal + 1);
         1: return POS_W'($urandom_range(255, 128));
         2: return POS_W'($urandom_range(127, 65));
         default: return POS_W'($urandom());
      endcase
   endfunction

   // random items in runs that grow, shrink or churn the list, so that it
   // regularly reaches capacity and empties again
   task automatic random_items(input int count);
      int               run_left;
      int               mode;
      int               r;
      logic [CMD_W-1:0] cmd;
      run_left = 0;
      mode     = 0;
      for (int k = 0; k < count; k++) begin
         if (run_left == 0) begin
            mode     = $urandom_range(3);   // 0 and 1 grow, 2 shrink, 3 churn
            run_left = $urandom_range(160, 40);
         end
         run_left--;
         r = $urandom_range(99);
         if (r < 1) begin
            cmd = CMD_W'($urandom_range(7, 5));   // undefined commands
         end else if (r < 3 && mode >= 2) begin
            cmd = CMD_CLEAR;
         end else begin
            r = $urandom_range(99);
            if (mode <= 1) begin
               cmd = (r < 75) ? CMD_INSERT : (r < 85) ? CMD_REMOVE :
                     (r < 93) ? CMD_GET : CMD_REPLACE;
            end else if (mode == 2) begin
               cmd = (r < 20) ? CMD_INSERT : (r < 75) ? CMD_REMOVE :
                     (r < 88) ? CMD_GET : CMD_REPLACE;
            end else begin
               cmd = (r < 35) ? CMD_INSERT : (r < 65) ? CMD_REMOVE :
                     (r < 85) ? CMD_GET : CMD_REPLACE;
            end
         end
         send_item(cmd, pick_position(cmd), $urandom());
      end
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty list refusals
      send_item(CMD_GET,     8'd0, 32'h0);
      send_item(CMD_REMOVE,  8'd0, 32'h0);
      send_item(CMD_REPLACE, 8'd0, 32'hDEAD_BEEF);
      // append, insert at the front, insert at the end by index
      send_item(CMD_INSERT,  POS_APPEND, 32'h0000_0000);
      send_item(CMD_INSERT,  8'd0, 32'hFFFF_FFFF);
      send_item(CMD_INSERT,  8'd2, 32'hA5A5_A5A5);
      // insert refusals: past the end, negative other than append, extremes
      send_item(CMD_INSERT,  8'd4, 32'h1111_1111);
      send_item(CMD_INSERT,  8'hFE, 32'h2222_2222);
      send_item(CMD_INSERT,  8'h80, 32'h3333_3333);
      send_item(CMD_INSERT,  8'h7F, 32'h4444_4444);
      // reads, including -1 which only insert accepts
      send_item(CMD_GET,     POS_APPEND, 32'h0);
      send_item(CMD_GET,     8'd0, 32'h0);
      send_item(CMD_GET,     8'd1, 32'h0);
      send_item(CMD_GET,     8'd3, 32'h0);
      send_item(CMD_REPLACE, 8'd1, 32'h1234_5678);
      send_item(CMD_GET,     8'd1, 32'h0);
      // remove at the end and at the front
      send_item(CMD_REMOVE,  8'd2, 32'h0);
      send_item(CMD_REMOVE,  8'd0, 32'h0);
      // undefined commands leave the list alone
      send_item(3'd5, 8'd0, 32'hFFFF_FFFF);
      send_item(3'd6, 8'hFF, 32'h0);
      send_item(3'd7, 8'd0, 32'h5A5A_5A5A);
      // clear keeps contents hidden behind a zero count
      send_item(CMD_CLEAR,   8'd0, 32'h0);
      send_item(CMD_GET,     8'd0, 32'h0);
      send_item(CMD_REMOVE,  POS_APPEND, 32'h0);

      // random part in three pressure settings
      random_items(RANDOM_ITEMS / 3);
      send_idle_pct = 54;
      recv_idle_pct <= 20;
      random_items(RANDOM_ITEMS / 3);
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      random_items(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
      req_tvalid <= 1'b0;

      // let every result come out, then watch for strays
      while (awaiting != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("%0d items sent under three back-pressure mixes, %0d results checked",
               items_sent, results_seen);
      $display("list at capacity in %0d results, %0d refusals for position or full list",
               full_seen, refusals);
      if (mismatches == 0 && awaiting == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
